// ----- rtl/b64d_pkg.sv -----
package b64d_pkg;

  // Default width of the decoded byte counter
  localparam int COUNT_BITS_DEF = 16;

  // Depth of the result queue; it must hold one full step (four beats) more
  localparam int QUEUE_DEPTH = 8;
  localparam int STEP_ITEMS  = 4;

  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
  localparam logic [7:0]  PAD_CHAR       = 8'h3D;
  localparam logic [6:0]  SEXTET_NONE    = 7'd64;

  // Status codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_LENGTH = 3'd1;
  localparam logic [2:0] ERR_CHAR   = 3'd2;
  localparam logic [2:0] ERR_PAD    = 3'd3;
  localparam logic [2:0] ERR_BITS   = 3'd4;
  localparam logic [2:0] ERR_ROOM   = 3'd5;

  // One result beat
  typedef struct packed {
    logic        is_status;
    logic [7:0]  data_byte;
    logic [2:0]  status_code;
    logic [15:0] byte_count;
    logic        last_out;
  } item_t;

  // Map a character to its sextet; bit 6 set means not in the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = SEXTET_NONE;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

// ----- rtl/b64d_decode.sv -----
module b64d_decode import b64d_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [7:0]             ch,
  input  logic                   last,
  input  logic [15:0]            capacity,
  output item_t [STEP_ITEMS-1:0] items,
  output logic [2:0]             n_items
);

  localparam int SW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

  logic [23:0]           sextet_acc, sextet_acc_next;
  logic [1:0]            group_pos, group_pos_next;
  logic [1:0]            pad_seen, pad_seen_next;
  logic [COUNT_BITS-1:0] bytes_out, bytes_out_next;
  logic [2:0]            error_code, error_code_next;

  logic [6:0]  v;
  logic [1:0]  need;
  logic [SW-1:0] sum, cap_ext, max_ext, cnt_ext;
  logic [23:0] x;

  // Decode one character against the group state
  always_comb begin
    sextet_acc_next = sextet_acc;
    group_pos_next  = group_pos;
    pad_seen_next   = pad_seen;
    bytes_out_next  = bytes_out;
    error_code_next = error_code;
    items           = '0;
    n_items         = 3'd0;
    v               = sextet_of(ch);
    need            = 2'd0;
    sum             = '0;
    cap_ext         = SW'(capacity);
    max_ext         = SW'({COUNT_BITS{1'b1}});
    cnt_ext         = '0;
    x               = '0;

    if (error_code == ERR_NONE) begin
      if (ch == PAD_CHAR) begin
        if (group_pos < 2'd2) begin
          error_code_next = ERR_PAD;
        end else begin
          pad_seen_next   = pad_seen + 2'd1;
          sextet_acc_next = {sextet_acc[17:0], 6'd0};
        end
      end else if (v[6]) begin
        error_code_next = ERR_CHAR;
      end else if (pad_seen != 2'd0) begin
        error_code_next = ERR_PAD;
      end else begin
        sextet_acc_next = {sextet_acc[17:0], v[5:0]};
      end

      if (error_code_next == ERR_NONE) begin
        if (group_pos == 2'd3) begin
          x              = sextet_acc_next;
          need           = 2'd3 - pad_seen_next;
          sum            = SW'(bytes_out) + SW'(need);
          group_pos_next = 2'd0;
          if (pad_seen_next != 2'd0 && !last) begin
            error_code_next = ERR_PAD;
          end else if ((pad_seen_next == 2'd1 && x[7:0] != 8'd0) ||
                       (pad_seen_next == 2'd2 && x[15:0] != 16'd0)) begin
            error_code_next = ERR_BITS;
          end else if (sum > cap_ext || sum > max_ext) begin
            error_code_next = ERR_ROOM;
          end else begin
            items[0].data_byte = x[23:16];
            items[1].data_byte = x[15:8];
            items[2].data_byte = x[7:0];
            n_items            = {1'b0, need};
            bytes_out_next     = sum[COUNT_BITS-1:0];
          end
          sextet_acc_next = '0;
          pad_seen_next   = 2'd0;
        end else begin
          group_pos_next = group_pos + 2'd1;
        end
      end
    end

    // Close the string with a status beat and clear for the next one
    if (last) begin
      if (error_code_next == ERR_NONE && group_pos_next != 2'd0) begin
        error_code_next = ERR_LENGTH;
      end
      cnt_ext                      = SW'(bytes_out_next);
      items[n_items[1:0]].is_status   = 1'b1;
      items[n_items[1:0]].status_code = error_code_next;
      items[n_items[1:0]].byte_count  = cnt_ext[15:0];
      items[n_items[1:0]].last_out    = 1'b1;
      n_items                      = n_items + 3'd1;
      sextet_acc_next              = '0;
      group_pos_next               = 2'd0;
      pad_seen_next                = 2'd0;
      bytes_out_next               = '0;
      error_code_next              = ERR_NONE;
    end
  end

  // Advance the group state on each decoded character
  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_acc <= '0;
      group_pos  <= 2'd0;
      pad_seen   <= 2'd0;
      bytes_out  <= '0;
      error_code <= ERR_NONE;
    end else if (fire) begin
      sextet_acc <= sextet_acc_next;
      group_pos  <= group_pos_next;
      pad_seen   <= pad_seen_next;
      bytes_out  <= bytes_out_next;
      error_code <= error_code_next;
    end
  end

endmodule

// ----- rtl/b64d_queue.sv -----
module b64d_queue import b64d_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  item_t [STEP_ITEMS-1:0] wr_items,
  input  logic [2:0]             wr_n,
  input  logic                   rd_en,
  output item_t                  rd_item,
  output logic                   not_empty,
  output logic                   has_room
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign pop       = rd_en && (count != '0);
  assign not_empty = (count != '0);
  assign has_room  = (count <= CW'(QUEUE_DEPTH - STEP_ITEMS));
  assign rd_item   = mem[rd_ptr];

  // Store up to one step of beats at consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < STEP_ITEMS; i++) begin
      if (3'(i) < wr_n) begin
        mem[wr_ptr + AW'(i)] <= wr_items[i];
      end
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(wr_n);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + CW'(wr_n) - CW'(pop);
    end
  end

endmodule

// ----- rtl/base64_strict_decoder.sv -----
// An accepted character is registered, then decoded and written into the result queue.
// Throughput: one character per cycle, stalling while that queue holds more than four;
// a group of four characters yields up to three byte beats, and the last character adds
// one status beat; beats leave the eight-entry queue one per cycle while the sink is ready.
// Reset (rst, synchronous) clears the group state and queue and sets out_capacity to 65535.
module base64_strict_decoder import b64d_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] data_byte, [10:8] status_code, [26:11] byte_count
  output logic        m_axis_tuser,  // [0] is_status
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]           out_capacity;
  logic                  in_vld;
  logic [7:0]            in_char;
  logic                  in_last;
  logic                  fire;
  logic                  has_room;
  logic                  not_empty;
  item_t [STEP_ITEMS-1:0] step_items;
  logic [2:0]            step_n;
  item_t                 head;

  assign cfg_ready     = 1'b1;
  assign fire          = in_vld && has_room;
  assign s_axis_tready = !in_vld || fire;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      out_capacity <= cfg_data;
    end
  end

  // Capture an input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  b64d_decode #(.COUNT_BITS(COUNT_BITS)) u_decode (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .ch       (in_char),
    .last     (in_last),
    .capacity (out_capacity),
    .items    (step_items),
    .n_items  (step_n)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_items  (step_items),
    .wr_n      (fire ? step_n : 3'd0),
    .rd_en     (m_axis_tready),
    .rd_item   (head),
    .not_empty (not_empty),
    .has_room  (has_room)
  );

  // Drive the result channel from the queue head
  assign m_axis_tvalid = not_empty;
  assign m_axis_tuser  = head.is_status;
  assign m_axis_tlast  = head.last_out;
  assign m_axis_tdata  = {5'd0, head.byte_count, head.status_code, head.data_byte};

  // A step never emits more than one group of bytes and a status beat
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    fire |-> step_n <= 3'(STEP_ITEMS))
    else $error("decode step emits too many beats");

  // Status beats carry a defined code; byte beats carry no code, no count and no last flag
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[10:8] <= ERR_ROOM)
    else $error("status beat with undefined code");

  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (!m_axis_tlast && m_axis_tdata[26:8] == 19'd0))
    else $error("byte beat carries status fields");

  // A beat stalled at the input is decoded once room appears
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !has_room) |=> in_vld)
    else $error("captured character lost while stalled");

endmodule

// ----- test/b64d_result_check.sv -----
module b64d_result_check import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [7:0] data_byte, [10:8] status_code, [26:11] byte_count
  input  logic        m_axis_tuser,   // [0] is_status
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          failures,
  output int          pending
);

  localparam int COUNT_MAX = (1 << COUNT_BITS_DEF) - 1;

  // Decoder state as the block should hold it
  logic [15:0] capacity;
  logic [23:0] acc;
  logic [1:0]  pos;
  logic [1:0]  pads;
  int          produced;
  logic [2:0]  err;

  item_t decoded_beats_due[$];

  initial failures = 0;
  initial pending = 0;

  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return {1'b0, 6'(c - 8'h41)};
    if (c >= 8'h61 && c <= 8'h7A) return {1'b0, 6'(c - 8'h61 + 8'd26)};
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 6'(c - 8'h30 + 8'd52)};
    if (c == 8'h2B) return 7'd62;
    if (c == 8'h2F) return 7'd63;
    return 7'h40;
  endfunction

  task automatic clear_text();
    acc = '0;
    pos = '0;
    pads = '0;
    produced = 0;
    err = ERR_NONE;
  endtask

  task automatic push_byte(input logic [7:0] b);
    item_t beat;
    beat = '0;
    beat.data_byte = b;
    decoded_beats_due.push_back(beat);
  endtask

  // Work out the beats that one accepted character brings
  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [6:0]  v;
    logic [23:0] x;
    int          need;
    item_t       beat;
    v = sextet_value(c);
    if (err == ERR_NONE) begin
      if (c == PAD_CHAR) begin
        if (pos < 2) begin
          err = ERR_PAD;
        end else begin
          pads = pads + 1;
          acc = acc << 6;
        end
      end else if (v[6]) begin
        err = ERR_CHAR;
      end else if (pads != 0) begin
        err = ERR_PAD;
      end else begin
        acc = {acc[17:0], v[5:0]};
      end

      if (err == ERR_NONE) begin
        if (pos == 3) begin
          x = acc;
          need = 3 - pads;
          pos = 0;
          // a padded group must close the text and leave no stray bits
          if (pads != 0 && !fin) begin
            err = ERR_PAD;
          end else if ((pads == 1 && x[7:0] != 0) || (pads == 2 && x[15:0] != 0)) begin
            err = ERR_BITS;
          end else if (produced + need > capacity || produced + need > COUNT_MAX) begin
            err = ERR_ROOM;
          end else begin
            push_byte(x[23:16]);
            if (pads < 2) push_byte(x[15:8]);
            if (pads == 0) push_byte(x[7:0]);
            produced += need;
          end
          acc = '0;
          pads = '0;
        end else begin
          pos = pos + 1;
        end
      end
    end

    // close the text with its status beat
    if (fin) begin
      if (err == ERR_NONE && pos != 0) err = ERR_LENGTH;
      beat = '0;
      beat.is_status = 1'b1;
      beat.status_code = err;
      beat.byte_count = produced[15:0];
      beat.last_out = 1'b1;
      decoded_beats_due.push_back(beat);
      clear_text();
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (failures < 40) $display("mismatch at %0t: %s", $time, msg);
    failures++;
  endtask

  // Compare one output beat against the oldest beat due
  task automatic check_beat();
    item_t want;
    if (decoded_beats_due.size() == 0) begin
      report_mismatch($sformatf("beat with nothing due: data %h user %b last %b",
                                m_axis_tdata, m_axis_tuser, m_axis_tlast));
    end else begin
      want = decoded_beats_due.pop_front();
      if (m_axis_tuser != want.is_status)
        report_mismatch($sformatf("is_status %b, want %b", m_axis_tuser, want.is_status));
      if (m_axis_tdata[7:0] != want.data_byte)
        report_mismatch($sformatf("data_byte %h, want %h", m_axis_tdata[7:0],
                                  want.data_byte));
      if (m_axis_tdata[10:8] != want.status_code)
        report_mismatch($sformatf("status_code %0d, want %0d", m_axis_tdata[10:8],
                                  want.status_code));
      if (m_axis_tdata[26:11] != want.byte_count)
        report_mismatch($sformatf("byte_count %0d, want %0d", m_axis_tdata[26:11],
                                  want.byte_count));
      if (m_axis_tlast != want.last_out)
        report_mismatch($sformatf("last_out %b, want %b", m_axis_tlast, want.last_out));
    end
  endtask

  // Watch the three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      capacity = CAPACITY_RESET;
      clear_text();
      decoded_beats_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (s_axis_tvalid && s_axis_tready) decode_char(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_beat();
    end
    pending <= decoded_beats_due.size();
  end

endmodule

// ----- test/base64_strict_decoder_tb.sv -----
module base64_strict_decoder_tb import b64d_pkg::*;;

  localparam int LIMIT       = 400000;
  localparam int PHASES      = 5;
  localparam int PHASE_CHARS = 80;

  typedef logic [7:0] text_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] char_in
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [7:0] data_byte, [10:8] status_code, [26:11] byte_count
  logic        m_axis_tuser;        // [0] is_status
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int failures;
  int pending;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int chars_sent;

  // Idling per phase: sender gap and receiver stall, in percent
  int idle_tab[PHASES]  = '{0, 57, 0, 37, 37};
  int stall_tab[PHASES] = '{0, 0, 57, 37, 37};

  always #1 clk = ~clk;

  base64_strict_decoder DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  b64d_result_check decode_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .failures      (failures),
    .pending       (pending)
  );

  // Stall the result side at random
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Abandon a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 26) return 8'h41 + 8'(v);        // A..Z
    if (v < 52) return 8'h61 + 8'(v - 26);   // a..z
    if (v < 62) return 8'h30 + 8'(v - 52);   // 0..9
    if (v == 62) return 8'h2B;               // +
    return 8'h2F;                            // /
  endfunction

  function automatic text_t from_string(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  // Canonical encoding of n random bytes, padded to whole groups
  function automatic text_t encode_random(input int n);
    text_t       t;
    logic [23:0] x;
    int          rem;
    for (int i = 0; i < n; i += 3) begin
      rem = (n - i >= 3) ? 3 : n - i;
      x = {8'($urandom), 8'($urandom), 8'($urandom)};
      if (rem < 3) x[7:0] = '0;
      if (rem < 2) x[15:8] = '0;
      t.push_back(sextet_char(x[23:18]));
      t.push_back(sextet_char(x[17:12]));
      t.push_back(rem >= 2 ? sextet_char(x[11:6]) : PAD_CHAR);
      t.push_back(rem == 3 ? sextet_char(x[5:0]) : PAD_CHAR);
    end
    return t;
  endfunction

  function automatic int random_len();
    if ($urandom_range(19) == 0) return $urandom_range(30, 60);
    return $urandom_range(1, 12);
  endfunction

  // Mostly clean texts, the rest broken in one way or another
  function automatic text_t random_text();
    text_t t;
    text_t tail;
    int    k;
    int    n;
    int    p;
    k = $urandom_range(99);
    if (k < 60) begin
      t = encode_random(random_len());
    end else if (k < 68) begin
      t = encode_random(random_len());
      t[$urandom_range(t.size() - 1)] = 8'($urandom);
    end else if (k < 74) begin
      t = encode_random(random_len());
      if ($urandom_range(1)) t.delete($urandom_range(t.size() - 1));
      else t.push_back(sextet_char(6'($urandom)));
    end else if (k < 80) begin
      t = encode_random(random_len());
      t.insert($urandom_range(t.size()), PAD_CHAR);
    end else if (k < 87) begin
      // spoil the last data character ahead of the padding
      n = 3 * $urandom_range(0, 3) + $urandom_range(1, 2);
      t = encode_random(n);
      p = (n % 3 == 1) ? t.size() - 3 : t.size() - 2;
      t[p] = sextet_char(6'($urandom));
    end else if (k < 93) begin
      // padded group followed by more text
      t = encode_random(3 * $urandom_range(0, 2) + $urandom_range(1, 2));
      tail = encode_random($urandom_range(1, 6));
      foreach (tail[i]) t.push_back(tail[i]);
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(2))
          0:       t.push_back(8'($urandom));
          1:       t.push_back(sextet_char(6'($urandom)));
          default: t.push_back(PAD_CHAR);
        endcase
      end
    end
    return t;
  endfunction

  // Offer one character beat, with a random gap ahead of it
  task automatic send_char(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    chars_sent++;
  endtask

  task automatic send_text(input text_t t);
    foreach (t[i]) send_char(t[i], i == t.size() - 1);
  endtask

  // Hold until every due beat has come out and the block has drained
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] cap;
    text_t       t;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       cap = 16'hFFFF;
        1:       cap = 16'h0000;
        2:       cap = 16'd9;
        3:       cap = 16'($urandom_range(1, 30));
        default: cap = 16'hFFFF;
      endcase
      write_capacity(cap);
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];

      // Directed texts: all ones, each pad misuse, stray bits, bad length, bad char
      if (ph == 0) begin
        send_text(from_string("////"));
        send_text(from_string("TQ=A"));
        send_text(from_string("="));
        send_text(from_string("AA"));
        send_text(from_string("TR=="));
        send_text(from_string("TWF="));
        send_char(8'hFF, 1'b1);
        send_text(from_string("TQ==AAAA"));
      end

      chars_sent = 0;
      while (chars_sent < PHASE_CHARS) begin
        t = random_text();
        send_text(t);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/b64d_pkg.sv
rtl/b64d_decode.sv
rtl/b64d_queue.sv
rtl/base64_strict_decoder.sv
test/b64d_result_check.sv
test/base64_strict_decoder_tb.sv
